@@ design/slrg_pkg.sv @@
`timescale 1ns / 1ps

package slrg_pkg;

	// Field and datapath widths
	localparam int PERMILLE_W  = 10;
	localparam int PULSE_W     = 16;
	localparam int POS_W       = 20;
	localparam int SPEED_W     = 3;
	localparam int FUNC_W      = 3;
	localparam int MOTION_W    = 2;
	localparam int STEP_W      = 18;
	localparam int NXT_W       = 22;
	localparam int SPAN_W      = PULSE_W + 1;
	localparam int PROD_W      = PULSE_W + PERMILLE_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [PERMILLE_W-1:0] PERMILLE_MAX = 10'd1000;

	// Division by 1000 as a multiplication by ceil(2^36 / 1000) and a shift.
	// The product of span and permille stays below 2^26, so the rounding error
	// stays below 2^-10 and the quotient is exact.
	localparam int RECIP_W     = 27;
	localparam int RECIP_SHIFT = 36;
	localparam int SCALED_W    = PROD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;

	// One permille of a 1 ms period in nanoseconds
	localparam logic [POS_W-1:0] NS_PER_PERMILLE = 20'd1000;

	// Servo ramp steps in microseconds per tick
	localparam int SPEED_BASE = 5;
	localparam logic [PULSE_W-1:0] SERVO_STEP_1 = PULSE_W'(SPEED_BASE);
	localparam logic [PULSE_W-1:0] SERVO_STEP_2 = PULSE_W'(SPEED_BASE * 5);
	localparam logic [PULSE_W-1:0] SERVO_STEP_3 = PULSE_W'(SPEED_BASE * 8);
	localparam logic [PULSE_W-1:0] SERVO_STEP_4 = PULSE_W'(SPEED_BASE * 16);
	localparam logic [PULSE_W-1:0] SERVO_STEP_5 = PULSE_W'(SPEED_BASE * 25);

	// LED pulse steps in nanoseconds per tick
	localparam logic signed [STEP_W-1:0] LED_STEP_SLOW   = 18'sd50;
	localparam logic signed [STEP_W-1:0] LED_STEP_MEDIUM = 18'sd250;
	localparam logic signed [STEP_W-1:0] LED_STEP_FAST   = 18'sd5000;

	// Speed codes
	localparam logic [SPEED_W-1:0] SPEED_1 = 3'd1;
	localparam logic [SPEED_W-1:0] SPEED_2 = 3'd2;
	localparam logic [SPEED_W-1:0] SPEED_3 = 3'd3;
	localparam logic [SPEED_W-1:0] SPEED_4 = 3'd4;
	localparam logic [SPEED_W-1:0] SPEED_5 = 3'd5;

	// Commands
	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_ACTUATE = 1'b1;

	// Output modes
	localparam logic MODE_SERVO = 1'b0;
	localparam logic MODE_LED   = 1'b1;

	// Light functions
	localparam logic [FUNC_W-1:0] LF_OFF    = 3'd0;
	localparam logic [FUNC_W-1:0] LF_STEADY = 3'd1;
	localparam logic [FUNC_W-1:0] LF_SLOW   = 3'd2;
	localparam logic [FUNC_W-1:0] LF_MEDIUM = 3'd3;
	localparam logic [FUNC_W-1:0] LF_FAST   = 3'd4;

	// Motion states
	localparam logic [MOTION_W-1:0] MS_IDLE  = 2'd0;
	localparam logic [MOTION_W-1:0] MS_SERVO = 2'd1;
	localparam logic [MOTION_W-1:0] MS_LED   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_CODE   = 2'd3;

	localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 16'd1000;
	localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 16'd2000;

	typedef struct packed {
		logic                 output_mode;
		logic [PULSE_W-1:0]   min_pulse_us;
		logic [PULSE_W-1:0]   max_pulse_us;
		logic [SPEED_W-1:0]   servo_speed_code;
	} cfg_t;

	// One input word after the first stage: saturated levels and the
	// servo span product, ready for the update stage.
	typedef struct packed {
		logic                  cmd;
		logic [FUNC_W-1:0]     light_function;
		logic [PERMILLE_W-1:0] level_hi;
		logic [PERMILLE_W-1:0] level_lo;
		logic                  span_neg;
		logic [PULSE_W-1:0]    span_mag;
		logic [PROD_W-1:0]     span_prod;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]    pulse_value;
		logic [MOTION_W-1:0] motion_kind;
		logic                pwm_write;
	} result_t;

endpackage

@@ design/slrg_cfg.sv @@
`timescale 1ns / 1ps

module slrg_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [slrg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slrg_pkg::CFG_DATA_W-1:0] cfg_data,
	output slrg_pkg::cfg_t                 cfg
);
	import slrg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_mode      <= MODE_SERVO;
			cfg_q.min_pulse_us     <= MIN_PULSE_RESET;
			cfg_q.max_pulse_us     <= MAX_PULSE_RESET;
			cfg_q.servo_speed_code <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OUTPUT_MODE: cfg_q.output_mode      <= cfg_data[0];
				REG_MIN_PULSE:   cfg_q.min_pulse_us     <= cfg_data[PULSE_W-1:0];
				REG_MAX_PULSE:   cfg_q.max_pulse_us     <= cfg_data[PULSE_W-1:0];
				REG_SPEED_CODE:  cfg_q.servo_speed_code <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/slrg_core.sv @@
`timescale 1ns / 1ps

module slrg_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  slrg_pkg::item_t   item,
	input  slrg_pkg::cfg_t    cfg,
	output slrg_pkg::result_t res
);
	import slrg_pkg::*;

	logic [MOTION_W-1:0]      ms_q;
	logic [FUNC_W-1:0]        held_q;
	logic [POS_W-1:0]         pos_q;
	logic [PULSE_W-1:0]       tgt_q;
	logic signed [STEP_W-1:0] step_q;
	logic [POS_W-1:0]         upper_q;
	logic [POS_W-1:0]         lower_q;

	logic [MOTION_W-1:0]      ms_d;
	logic [FUNC_W-1:0]        held_d;
	logic [POS_W-1:0]         pos_d;
	logic [PULSE_W-1:0]       tgt_d;
	logic signed [STEP_W-1:0] step_d;
	logic [POS_W-1:0]         upper_d;
	logic [POS_W-1:0]         lower_d;
	logic                     wr;

	logic [SCALED_W-1:0]      scaled;
	logic [PULSE_W-1:0]       quot;
	logic [PULSE_W-1:0]       cmd_tgt;
	logic [PULSE_W-1:0]       step_mag;
	logic signed [STEP_W-1:0] step_ext;
	logic signed [STEP_W-1:0] cmd_step;
	logic [POS_W-1:0]         led_hi;
	logic [POS_W-1:0]         led_lo;
	logic signed [NXT_W-1:0]  nxt;
	logic signed [NXT_W-1:0]  tgt_ext;
	logic signed [NXT_W-1:0]  upper_ext;
	logic signed [NXT_W-1:0]  lower_ext;
	logic                     pulsing;

	function automatic logic [PULSE_W-1:0] servo_step(input logic [SPEED_W-1:0] code,
			input logic [PULSE_W-1:0] span_mag);
		case (code)
			SPEED_1: servo_step = SERVO_STEP_1;
			SPEED_2: servo_step = SERVO_STEP_2;
			SPEED_3: servo_step = SERVO_STEP_3;
			SPEED_4: servo_step = SERVO_STEP_4;
			SPEED_5: servo_step = SERVO_STEP_5;
			default: servo_step = span_mag;
		endcase
	endfunction

	// Servo target: min plus the span scaled by permille, truncated toward zero.
	assign scaled   = SCALED_W'(item.span_prod) * SCALED_W'(RECIP_1000);
	assign quot     = scaled[RECIP_SHIFT +: PULSE_W];
	assign cmd_tgt  = item.span_neg ? cfg.min_pulse_us - quot : cfg.min_pulse_us + quot;
	assign step_mag = servo_step(cfg.servo_speed_code, item.span_mag);
	assign step_ext = $signed({2'b00, step_mag});
	assign cmd_step = (POS_W'(cmd_tgt) < pos_q) ? -step_ext : step_ext;

	assign led_hi = POS_W'(item.level_hi) * NS_PER_PERMILLE;
	assign led_lo = POS_W'(item.level_lo) * NS_PER_PERMILLE;

	assign nxt       = $signed({2'b00, pos_q}) + NXT_W'(step_q);
	assign tgt_ext   = $signed({{(NXT_W - PULSE_W){1'b0}}, tgt_q});
	assign upper_ext = $signed({2'b00, upper_q});
	assign lower_ext = $signed({2'b00, lower_q});
	assign pulsing   = (held_q == LF_SLOW) || (held_q == LF_MEDIUM) || (held_q == LF_FAST);

	always_comb begin
		ms_d    = ms_q;
		held_d  = held_q;
		pos_d   = pos_q;
		tgt_d   = tgt_q;
		step_d  = step_q;
		upper_d = upper_q;
		lower_d = lower_q;
		wr      = 1'b0;
		if (item.cmd == CMD_ACTUATE) begin
			if (cfg.output_mode == MODE_SERVO) begin
				tgt_d  = cmd_tgt;
				step_d = cmd_step;
				ms_d   = MS_SERVO;
			end else begin
				ms_d    = MS_LED;
				held_d  = item.light_function;
				upper_d = led_hi;
				lower_d = led_lo;
				case (item.light_function)
					LF_STEADY: pos_d = led_hi;
					LF_SLOW: begin
						pos_d  = led_hi;
						step_d = LED_STEP_SLOW;
					end
					LF_MEDIUM: begin
						pos_d  = led_hi;
						step_d = LED_STEP_MEDIUM;
					end
					LF_FAST: begin
						pos_d  = led_hi;
						step_d = LED_STEP_FAST;
					end
					default: pos_d = '0;
				endcase
			end
		end else begin
			case (ms_q)
				MS_SERVO: begin
					wr = 1'b1;
					if (step_q == 0 || (step_q > 0 && nxt >= tgt_ext) ||
							(step_q < 0 && nxt <= tgt_ext)) begin
						pos_d = POS_W'(tgt_q);
						ms_d  = MS_IDLE;
					end else begin
						pos_d = nxt[POS_W-1:0];
					end
				end
				MS_LED: begin
					wr = 1'b1;
					if (pulsing) begin
						// Bounce between the two levels; the upper clamp wins.
						if (nxt >= upper_ext) begin
							step_d = -step_q;
							pos_d  = upper_q;
						end else if (nxt <= lower_ext) begin
							step_d = -step_q;
							pos_d  = lower_q;
						end else begin
							pos_d = nxt[POS_W-1:0];
						end
					end else begin
						ms_d = MS_IDLE;
					end
				end
				default: ms_d = MS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q    <= MS_IDLE;
			held_q  <= '0;
			pos_q   <= '0;
			tgt_q   <= '0;
			step_q  <= '0;
			upper_q <= '0;
			lower_q <= '0;
		end else if (upd) begin
			ms_q    <= ms_d;
			held_q  <= held_d;
			pos_q   <= pos_d;
			tgt_q   <= tgt_d;
			step_q  <= step_d;
			upper_q <= upper_d;
			lower_q <= lower_d;
		end
	end

	assign res.pulse_value = pos_d;
	assign res.motion_kind = ms_d;
	assign res.pwm_write   = wr;

	a_zero_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && item.cmd == CMD_TICK && ms_q == MS_SERVO && step_q == 0) |=>
		(ms_q == MS_IDLE && pos_q == POS_W'($past(tgt_q))))
		else $error("servo tick with zero step did not land on the target");

	a_servo_no_overshoot: assert property (@(posedge clk) disable iff (!arst_n)
		(ms_q == MS_SERVO && step_q > 0) |-> (pos_q <= POS_W'(tgt_q)))
		else $error("upward servo ramp passed its target");

	a_led_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(ms_q == MS_LED && pulsing) |->
		(pos_q == upper_q || pos_q == lower_q || (pos_q < upper_q && pos_q > lower_q)))
		else $error("LED pulse level left its bounds");

endmodule

@@ design/servo_led_ramp_generator.sv @@
`timescale 1ns / 1ps

// Servo / LED ramp generator. Every input word yields exactly one result word.
// Input channel: in_valid with in_stall; a word (cmd, light_function,
// first_permille, second_permille) is taken at a clock edge with in_valid high
// and in_stall low. An actuate command starts a servo ramp toward a permille
// position between min_pulse_us and max_pulse_us, or sets an LED function;
// a tick advances the current motion by one step.
// Output channel: out_valid with out_stall; a word (pulse_value, motion_kind,
// pwm_write) leaves at an edge with out_valid high and out_stall low.
// Configuration: cfg_we, cfg_index and cfg_data write one register per edge;
// write only while no word is in flight.
// An accepted word is held in the input register; when it moves on, it updates
// the state, and its result is registered and shown on the output from then on.
// Throughput is one word per cycle while out_stall stays low; the single update
// stage, one multiply deep, sets that figure.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; in_stall rises only when both are full.
// Reset clears the motion state and both pipeline stages, and loads the
// register defaults: servo mode, 1000 to 2000 us, servo step equal to the span.

module servo_led_ramp_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [slrg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slrg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [slrg_pkg::FUNC_W-1:0]     light_function,
	input  logic [slrg_pkg::PERMILLE_W-1:0] first_permille,
	input  logic [slrg_pkg::PERMILLE_W-1:0] second_permille,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [slrg_pkg::POS_W-1:0]      pulse_value,
	output logic [slrg_pkg::MOTION_W-1:0]   motion_kind,
	output logic                           pwm_write
);
	import slrg_pkg::*;

	cfg_t    cfg;
	item_t   item_d;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_s2;
	logic    valid_s2;

	logic                     in_acc;
	logic                     adv;
	logic signed [SPAN_W-1:0] span;
	logic [SPAN_W-1:0]        span_abs;

	slrg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// First stage: saturate both levels to 1000 permille and form the product
	// of the servo span magnitude and the position, so the update stage only
	// has to scale it by 1/1000.
	assign span     = $signed({1'b0, cfg.max_pulse_us}) - $signed({1'b0, cfg.min_pulse_us});
	assign span_abs = span[SPAN_W-1] ? -span : span;

	always_comb begin
		item_d.cmd            = cmd;
		item_d.light_function = light_function;
		item_d.level_hi       = (first_permille > PERMILLE_MAX) ? PERMILLE_MAX : first_permille;
		item_d.level_lo       = (second_permille > PERMILLE_MAX) ? PERMILLE_MAX : second_permille;
		item_d.span_neg       = span[SPAN_W-1];
		item_d.span_mag       = span_abs[PULSE_W-1:0];
		item_d.span_prod      = PROD_W'(item_d.span_mag) * PROD_W'(item_d.level_hi);
	end

	// The input stage moves on whenever the result register is empty or its
	// word is being taken this cycle.
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_d;
		end
	end

	slrg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid   = valid_s2;
	assign pulse_value = res_s2.pulse_value;
	assign motion_kind = res_s2.motion_kind;
	assign pwm_write   = res_s2.pwm_write;

	a_empty_output_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> !in_stall)
		else $error("input stalled while the result register was empty");

	a_stage_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (!valid_s2 || !out_stall)) |=> valid_s2)
		else $error("a word in the input stage was lost on its way out");

endmodule
